// ===== hw/rtl/vstg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstg_pkg: shared definitions for the vector stroke text generator
// Coordinate width, font contents, glyph directory, state and register codes.
// ----------------------------------------------------------------------------
package vstg_pkg;

    localparam int COORD_BITS          = 16;
    localparam int GLYPH_POINTS_DEF    = 256;
    localparam int SCALE_FRAC_BITS_DEF = 4;

    localparam int STEP_X    = 11;
    localparam int STEP_Y    = 19;
    localparam int FONT_SIZE = 186;
    localparam int GLYPHS    = 37;

    // font word: [3:0] gx, [8:4] -gy, [9] first point of a polyline, [10] zero
    localparam int WORD_W  = 11;
    localparam int MUL_A_W = 5;
    localparam int MUL_B_W = 8;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DELTA_W = PROD_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [WORD_W-1:0]              t_font_word;
    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic signed [DELTA_W-1:0]      t_delta;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X,
        CFG_SCALE_Y,
        CFG_SCREEN_WIDTH,
        CFG_LINE_COLOR
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_X,
        ST_MUL_Y,
        ST_EMIT,
        ST_ADV_X,
        ST_WRAP_CHK,
        ST_ADV_Y
    } t_state;

    typedef struct packed {
        logic       known;
        logic [7:0] start;
        logic [2:0] len;
    } t_glyph_info;

    function automatic t_font_word ps(input int x, input int m);
        return WORD_W'(32'h200 | (m << 4) | x);
    endfunction

    function automatic t_font_word pn(input int x, input int m);
        return WORD_W'((m << 4) | x);
    endfunction

    localparam t_font_word FONT [FONT_SIZE] = '{
        // 0 .. 9
        ps(0,0),pn(0,16),pn(8,16),pn(8,0),pn(0,0),pn(0,0),pn(8,16),
        ps(2,0),pn(6,0),ps(4,0),pn(4,16),pn(3,16),
        ps(0,16),pn(8,16),pn(8,8),pn(0,8),pn(0,0),pn(8,0),
        ps(0,16),pn(8,16),pn(8,0),pn(0,0),ps(2,8),pn(8,8),
        ps(0,16),pn(0,8),pn(8,8),ps(8,16),pn(8,0),
        ps(8,16),pn(0,16),pn(0,8),pn(8,8),pn(8,0),pn(0,0),
        ps(8,16),pn(0,16),pn(0,0),pn(8,0),pn(8,8),pn(0,8),
        ps(0,16),pn(8,16),pn(8,0),
        ps(0,0),pn(0,16),pn(8,16),pn(8,0),pn(0,0),ps(0,8),pn(8,8),
        ps(0,0),pn(8,0),pn(8,16),pn(0,16),pn(0,8),pn(8,8),
        // A .. Z
        ps(0,0),pn(4,16),pn(8,0),ps(2,8),pn(6,8),
        ps(0,0),pn(0,16),pn(8,12),pn(0,8),pn(8,4),pn(0,0),
        ps(8,0),pn(0,0),pn(0,16),pn(8,16),
        ps(0,0),pn(0,16),pn(8,8),pn(0,0),
        ps(8,0),pn(0,0),pn(0,16),pn(8,16),ps(0,8),pn(6,8),
        ps(0,0),pn(0,16),pn(8,16),ps(0,8),pn(6,8),
        ps(8,16),pn(0,16),pn(0,0),pn(8,0),pn(8,8),pn(4,8),pn(4,6),
        ps(0,0),pn(0,16),ps(0,8),pn(8,8),ps(8,0),pn(8,16),
        ps(3,0),pn(5,0),ps(3,16),pn(5,16),ps(4,0),pn(4,16),
        ps(8,16),pn(8,0),pn(0,0),pn(0,4),
        ps(0,0),pn(0,16),ps(8,16),pn(0,8),pn(8,0),
        ps(0,16),pn(0,0),pn(8,0),
        ps(0,0),pn(0,16),pn(4,8),pn(8,16),pn(8,0),
        ps(0,0),pn(0,16),pn(8,0),pn(8,16),
        ps(0,0),pn(0,16),pn(8,16),pn(8,0),pn(0,0),
        ps(0,0),pn(0,16),pn(8,16),pn(8,8),pn(0,8),
        ps(0,0),pn(0,16),pn(8,16),pn(8,0),pn(0,0),ps(8,0),pn(4,4),
        ps(0,0),pn(0,16),pn(8,16),pn(8,8),pn(0,8),ps(4,8),pn(8,0),
        ps(8,16),pn(0,16),pn(0,8),pn(8,8),pn(8,0),pn(0,0),
        ps(0,16),pn(8,16),ps(4,0),pn(4,16),
        ps(0,16),pn(0,0),pn(8,0),pn(8,16),
        ps(0,16),pn(4,0),pn(8,16),
        ps(0,16),pn(2,0),pn(4,8),pn(6,0),pn(8,16),
        ps(0,16),pn(8,0),ps(8,16),pn(0,0),
        ps(0,16),pn(4,8),pn(8,16),ps(4,8),pn(4,0),
        ps(0,16),pn(8,16),pn(0,0),pn(8,0)
    };

    // digits, capitals, then space
    localparam logic [7:0] GLYPH_START [GLYPHS] = '{
        8'd0,   8'd7,   8'd12,  8'd18,  8'd24,  8'd29,  8'd35,  8'd41,  8'd44,  8'd51,
        8'd57,  8'd62,  8'd68,  8'd72,  8'd76,  8'd82,  8'd87,  8'd94,  8'd100, 8'd106,
        8'd110, 8'd115, 8'd118, 8'd123, 8'd127, 8'd132, 8'd137, 8'd144, 8'd151, 8'd157,
        8'd161, 8'd165, 8'd168, 8'd173, 8'd177, 8'd182, 8'd186
    };

    localparam logic [2:0] GLYPH_LEN [GLYPHS] = '{
        3'd7, 3'd5, 3'd6, 3'd6, 3'd5, 3'd6, 3'd6, 3'd3, 3'd7, 3'd6,
        3'd5, 3'd6, 3'd4, 3'd4, 3'd6, 3'd5, 3'd7, 3'd6, 3'd6, 3'd4,
        3'd5, 3'd3, 3'd5, 3'd4, 3'd5, 3'd5, 3'd7, 3'd7, 3'd6, 3'd4,
        3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd4, 3'd0
    };

    function automatic t_glyph_info glyph_lookup(input logic [7:0] c);
        logic [5:0]  g;
        t_glyph_info info;
        g          = '0;
        info.known = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            g = 6'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            g = 6'(c - 8'h41 + 8'd10);
        end else if (c == 8'h20) begin
            g = 6'd36;
        end else begin
            info.known = 1'b0;
        end
        info.start = GLYPH_START[g];
        info.len   = GLYPH_LEN[g];
        return info;
    endfunction

    // pen plus a scaled offset, clamped to the signed coordinate range
    function automatic t_coord sat_add(input t_coord p, input t_delta d);
        logic signed [COORD_BITS:0] s;
        s = {p[COORD_BITS-1], p} + {{(COORD_BITS+1-DELTA_W){d[DELTA_W-1]}}, d};
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return s[COORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vstg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstg_if: character and segment channels
// Valid/ready channels carrying one character request and one line segment.
// ----------------------------------------------------------------------------
interface vstg_char_if import vstg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [7:0]         char_code;
    logic               message_start;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;

    modport source (output valid, char_code, message_start, start_x, start_y,
                    input ready);
    modport sink   (input valid, char_code, message_start, start_x, start_y,
                    output ready);
endinterface

interface vstg_seg_if import vstg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] seg_x0;
    logic signed [15:0] seg_y0;
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic               last_segment;

    modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
                    input ready);
    modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vstg_glyph_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstg_glyph_rom: stroke font point store
// Constant point table with a registered read; entries past the font are zero.
// ----------------------------------------------------------------------------
module vstg_glyph_rom import vstg_pkg::*; #(
    parameter int DEPTH  = GLYPH_POINTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic [WORD_W-1:0]      o_data
);

    logic [WORD_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_addr < ADDR_W'(FONT_SIZE)) begin
            r_data <= FONT[i_addr[7:0]];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== hw/rtl/vector_stroke_text_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector_stroke_text_generator_top: stroke font character generator
// Turns character requests into scaled, pen-offset line segments.
// ----------------------------------------------------------------------------
// One character request is taken while the block is idle. A code outside
// 0-9, A-Z and space finishes in the cycle it is taken. A known glyph
// walks its points in order (font read, x scale, y scale, segment out),
// then advances the pen and checks for a line wrap, with one more step
// for the y advance when the line wraps; a glyph has at most seven points;
// all scaling shares one small multiplier, and a segment that is not taken
// holds the walk. The last segment of a glyph waits in the output register
// while the next request is accepted.
module vector_stroke_text_generator_top import vstg_pkg::*; #(
    parameter int GLYPH_POINTS    = GLYPH_POINTS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    vstg_char_if.sink                  i_char,
    vstg_seg_if.source                 o_seg
);

    localparam int ADDR_W = $clog2(GLYPH_POINTS);

    t_state r_state, n_state;

    logic [7:0]  r_scale_x, r_scale_y;
    logic [11:0] r_screen_width;

    t_coord r_pen_x, n_pen_x;
    t_coord r_pen_y, n_pen_y;
    t_coord r_line_start_x, n_line_start_x;

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [2:0]        r_k, n_k;
    logic [2:0]        r_len, n_len;
    t_delta            r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    t_delta            r_cur_x, n_cur_x, r_cur_y, n_cur_y;

    logic   r_out_valid, n_out_valid;
    t_coord r_seg_x0, n_seg_x0, r_seg_y0, n_seg_y0;
    t_coord r_seg_x1, n_seg_x1, r_seg_y1, n_seg_y1;
    logic   r_last, n_last;

    t_font_word  rom_word;
    t_glyph_info ginfo;

    // shared scale unit
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [PROD_W-1:0]  mul_res;
    t_delta             mul_delta;

    logic emit_fire;
    logic point_done;
    logic last_point;
    logic wrap;

    vstg_glyph_rom #(
        .DEPTH  (GLYPH_POINTS),
        .ADDR_W (ADDR_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_data (rom_word)
    );

    assign mul_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mul_res   = mul_prod >> SCALE_FRAC_BITS;
    assign mul_delta = $signed({1'b0, mul_res});

    assign ginfo      = glyph_lookup(i_char.char_code);
    assign last_point = (r_k == 3'(r_len - 3'd1));
    assign wrap       = ($signed({{2{r_pen_x[COORD_BITS-1]}}, r_pen_x}) + 18'sd11)
                        >= $signed({6'd0, r_screen_width});

    assign i_char.ready       = (r_state == ST_IDLE);
    assign o_seg.valid        = r_out_valid;
    assign o_seg.seg_x0       = r_seg_x0;
    assign o_seg.seg_y0       = r_seg_y0;
    assign o_seg.seg_x1       = r_seg_x1;
    assign o_seg.seg_y1       = r_seg_y1;
    assign o_seg.last_segment = r_last;

    always_comb begin
        n_state        = r_state;
        n_pen_x        = r_pen_x;
        n_pen_y        = r_pen_y;
        n_line_start_x = r_line_start_x;
        n_addr         = r_addr;
        n_k            = r_k;
        n_len          = r_len;
        n_prev_x       = r_prev_x;
        n_prev_y       = r_prev_y;
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_seg_x0       = r_seg_x0;
        n_seg_y0       = r_seg_y0;
        n_seg_x1       = r_seg_x1;
        n_seg_y1       = r_seg_y1;
        n_last         = r_last;
        mul_a          = '0;
        mul_b          = r_scale_x;
        emit_fire      = 1'b0;
        point_done     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_char.valid) begin
                    if (i_char.message_start) begin
                        n_pen_x        = i_char.start_x;
                        n_line_start_x = i_char.start_x;
                        n_pen_y        = i_char.start_y;
                    end
                    n_addr   = ADDR_W'(ginfo.start);
                    n_len    = ginfo.len;
                    n_k      = '0;
                    n_prev_x = '0;
                    n_prev_y = '0;
                    priority if (!ginfo.known) begin
                        n_state = ST_IDLE;
                    end else if (ginfo.len == 3'd0) begin
                        n_state = ST_ADV_X;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_MUL_X;
            end
            ST_MUL_X: begin
                mul_a   = {1'b0, rom_word[3:0]};
                mul_b   = r_scale_x;
                n_cur_x = mul_delta;
                n_state = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                mul_a   = rom_word[8:4];
                mul_b   = r_scale_y;
                n_cur_y = -mul_delta;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (rom_word[9]) begin
                    point_done = 1'b1;
                end else if (!r_out_valid || o_seg.ready) begin
                    emit_fire  = 1'b1;
                    point_done = 1'b1;
                    n_seg_x0   = sat_add(r_pen_x, r_prev_x);
                    n_seg_y0   = sat_add(r_pen_y, r_prev_y);
                    n_seg_x1   = sat_add(r_pen_x, r_cur_x);
                    n_seg_y1   = sat_add(r_pen_y, r_cur_y);
                    // every glyph ends on a drawn point
                    n_last     = last_point;
                end
                if (point_done) begin
                    n_prev_x = r_cur_x;
                    n_prev_y = r_cur_y;
                    if (last_point) begin
                        n_state = ST_ADV_X;
                    end else begin
                        n_k     = 3'(r_k + 3'd1);
                        n_addr  = ADDR_W'(r_addr + 1'b1);
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_ADV_X: begin
                mul_a   = MUL_A_W'(STEP_X);
                mul_b   = r_scale_x;
                n_pen_x = sat_add(r_pen_x, mul_delta);
                n_state = ST_WRAP_CHK;
            end
            ST_WRAP_CHK: begin
                if (wrap) begin
                    n_pen_x = r_line_start_x;
                    n_state = ST_ADV_Y;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADV_Y: begin
                mul_a   = MUL_A_W'(STEP_Y);
                mul_b   = r_scale_y;
                n_pen_y = sat_add(r_pen_y, mul_delta);
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (o_seg.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_pen_x        <= '0;
            r_pen_y        <= '0;
            r_line_start_x <= '0;
        end else begin
            r_out_valid    <= n_out_valid;
            r_pen_x        <= n_pen_x;
            r_pen_y        <= n_pen_y;
            r_line_start_x <= n_line_start_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_k      <= n_k;
        r_len    <= n_len;
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_seg_x0 <= n_seg_x0;
        r_seg_y0 <= n_seg_y0;
        r_seg_x1 <= n_seg_x1;
        r_seg_y1 <= n_seg_y1;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x      <= 8'd16;
            r_scale_y      <= 8'd16;
            r_screen_width <= 12'd640;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_X:      r_scale_x      <= i_cfg_data[7:0];
                CFG_SCALE_Y:      r_scale_y      <= i_cfg_data[7:0];
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[11:0];
                // color belongs to the line drawer, nothing here depends on it
                CFG_LINE_COLOR:   ;
            endcase
        end
    end

    a_seg_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("segment raised outside emit step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && !o_seg.ready && !rom_word[9])
        |=> r_state == ST_EMIT && $stable(r_seg_x1) && $stable(r_seg_y1))
        else $error("pending segment overwritten");

    a_point_in_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH || r_state == ST_MUL_X || r_state == ST_MUL_Y
         || r_state == ST_EMIT) |-> (r_len != 3'd0 && r_k < r_len))
        else $error("point walk past glyph end");

    a_wrap_to_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV_Y) |-> r_pen_x == r_line_start_x)
        else $error("wrap did not return pen to line start");

endmodule
`default_nettype wire
